@@ sv/b64d_pkg.sv @@
// Shared types, constants and the alphabet lookup for the base64 decoder.
// No dependencies; compiled first.
`default_nettype none

package b64d_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

    // Depth of the job queue between the front and back parts
    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    // One decoded job: an optional error item, then n_bytes bytes from the top of data
    typedef struct packed {
        logic [23:0] data;
        logic [1:0]  n_bytes;
        logic        bad;
    } t_job;

    // Lookup result of one character: hit flag and 6-bit value
    typedef struct packed {
        logic       hit;
        logic [5:0] value;
    } t_sextet;

    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet s;
        s.hit   = 1'b1;
        s.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s.value = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            s.value = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            s.value = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            s.value = 6'd62;
        end else if (c == 8'h2F) begin
            s.value = 6'd63;
        end else begin
            s.hit = 1'b0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

@@ sv/b64d_if.sv @@
// Valid/ready channel interfaces for the base64 decoder: characters in,
// jobs between front and back, bytes out. Depends on b64d_pkg.
`default_nettype none

interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;
    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface b64d_job_if;
    import b64d_pkg::*;
    logic valid;
    logic ready;
    t_job job;
    modport source (output valid, output job, input ready);
    modport sink   (input valid, input job, output ready);
endinterface

interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       bad_char;
    logic       last_of_run;
    modport source (output valid, output data_byte, output bad_char, output last_of_run,
                    input ready);
    modport sink   (input valid, input data_byte, input bad_char, input last_of_run,
                    output ready);
endinterface

`default_nettype wire

@@ sv/b64d_front.sv @@
// Front part: accepts characters, tracks the open group and turns each
// character into a job of up to three results, or into none. Depends on b64d_pkg, b64d_if.
`default_nettype none

module b64d_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    b64d_char_if.sink        i_char,
    b64d_job_if.source       o_job
);
    import b64d_pkg::*;

    logic [17:0] r_bits, n_bits;
    logic [1:0]  r_cnt,  n_cnt;
    t_sextet     w_sx;
    logic        w_close;
    logic        w_take;
    t_job        w_job;

    always_comb begin
        w_sx        = sextet_of(i_char.char_code);
        n_bits      = r_bits;
        n_cnt       = r_cnt;
        w_close     = i_char.end_of_text;
        w_job.data  = 24'd0;
        w_job.n_bytes = 2'd0;
        w_job.bad   = 1'b0;

        if (i_char.char_code == PAD_CHAR) begin
            w_close = 1'b1;
        end else if (w_sx.hit) begin
            if (r_cnt == 2'd3) begin
                // fourth character completes the group
                w_job.data    = {r_bits, w_sx.value};
                w_job.n_bytes = 2'd3;
                n_bits        = 18'd0;
                n_cnt         = 2'd0;
                w_close       = 1'b0;
            end else begin
                n_bits = {r_bits[11:0], w_sx.value};
                n_cnt  = r_cnt + 2'd1;
            end
        end else begin
            w_job.bad = 1'b1;
        end

        if (w_close) begin
            // left-align a partial group; one lone character gives nothing
            unique case (n_cnt)
                2'd2: begin
                    w_job.data    = {n_bits[11:0], 12'd0};
                    w_job.n_bytes = 2'd1;
                end
                2'd3: begin
                    w_job.data    = {n_bits, 6'd0};
                    w_job.n_bytes = 2'd2;
                end
                default: ;
            endcase
            n_bits = 18'd0;
            n_cnt  = 2'd0;
        end
    end

    assign i_char.ready = o_job.ready;
    assign w_take       = i_char.valid && i_char.ready;
    assign o_job.valid  = i_char.valid && (w_job.bad || (w_job.n_bytes != 2'd0));
    assign o_job.job    = w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= 18'd0;
            r_cnt  <= 2'd0;
        end else if (w_take) begin
            r_bits <= n_bits;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

@@ sv/b64d_queue.sv @@
// Short job queue between the front and back parts, so either can stall
// on its own. Depends on b64d_pkg, b64d_if.
`default_nettype none

module b64d_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    b64d_job_if.sink         i_job,
    b64d_job_if.source       o_job
);
    import b64d_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, n_wr;
    logic [QAW-1:0] r_rd, n_rd;
    logic [QCW-1:0] r_cnt;
    logic           w_push, w_pop;

    assign i_job.ready = (r_cnt != QCW'(QDEPTH));
    assign o_job.valid = (r_cnt != '0);
    assign o_job.job   = r_mem[r_rd];

    assign w_push = i_job.valid && i_job.ready;
    assign w_pop  = o_job.valid && o_job.ready;

    assign n_wr = (r_wr == QAW'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == QAW'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= n_wr;
            if (w_pop)  r_rd <= n_rd;
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_job.job;
    end

endmodule

`default_nettype wire

@@ sv/b64d_back.sv @@
// Back part: unrolls one job into its result items, one per cycle while
// o_byte is ready, from an output register. Depends on b64d_pkg, b64d_if.
`default_nettype none

module b64d_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    b64d_job_if.sink         i_job,
    b64d_byte_if.source      o_byte
);
    import b64d_pkg::*;

    logic        r_busy;
    logic [23:0] r_data;
    logic [1:0]  r_left;
    logic        r_bad;
    logic        w_last, w_fire, w_free;

    assign w_last = r_bad ? (r_left == 2'd0) : (r_left == 2'd1);
    assign w_fire = r_busy && o_byte.ready;
    assign w_free = !r_busy || (w_fire && w_last);

    assign i_job.ready        = w_free;
    assign o_byte.valid       = r_busy;
    assign o_byte.data_byte   = r_bad ? 8'd0 : r_data[23:16];
    assign o_byte.bad_char    = r_bad;
    assign o_byte.last_of_run = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_free) begin
            r_busy <= i_job.valid;
        end
    end

    // error item goes first, then advance through the bytes
    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_data <= i_job.job.data;
            r_left <= i_job.job.n_bytes;
            r_bad  <= i_job.job.bad;
        end else if (w_fire) begin
            if (r_bad) begin
                r_bad <= 1'b0;
            end else begin
                r_data <= {r_data[15:0], 8'd0};
                r_left <= r_left - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/base64_decoder.sv @@
// Base64 (standard alphabet) text-to-byte decoder, top level.
// Depends on b64d_pkg, b64d_if, b64d_front, b64d_queue, b64d_back.
//
// Usage:
//   i_char carries one text character per item with an end-of-text flag.
//   o_byte carries decoded bytes; each input item gives zero to three
//   items, the last of them flagged by last_of_run. A character outside
//   the alphabet gives one item with bad_char set and data_byte zero.
//   Four characters give three bytes; '=' or end of text closes a partial
//   group of n characters into n-1 left-aligned bytes.
// Timing:
//   One character is accepted per cycle while i_char.ready is high. The first
//   result of an item is registered in the job queue, then in the output
//   register; further results follow one per cycle while o_byte.ready is
//   high. The output register emits at most one byte per cycle, so sustained
//   input is one character per cycle for ordinary text (three bytes per four characters).
// Reset and stall:
//   Synchronous reset clears the open group, the queue and the output.
//   When the receiver stalls, the output holds, the two-entry job queue
//   fills and then i_char.ready drops until the backlog drains.
`default_nettype none

module base64_decoder (
    input  wire              i_clk,
    input  wire              i_rst_n,
    b64d_char_if.sink        i_char,
    b64d_byte_if.source      o_byte
);
    import b64d_pkg::*;

    b64d_job_if w_fq ();
    b64d_job_if w_qb ();

    b64d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .o_job   (w_fq)
    );

    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_fq),
        .o_job   (w_qb)
    );

    b64d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_qb),
        .o_byte  (o_byte)
    );

`ifndef ASSERT_OFF
    a_job_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fq.valid |-> (w_fq.job.bad || (w_fq.job.n_bytes != 2'd0)))
        else $error("front pushed a job with no results");

    a_job_max3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fq.valid && w_fq.job.bad) |-> (w_fq.job.n_bytes != 2'd3))
        else $error("job holds more than three results");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte.valid && o_byte.bad_char) |-> (o_byte.data_byte == 8'd0))
        else $error("error item carries nonzero data");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_byte.valid)
        else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire
